>>> hdl/ofd_pkg.sv
`default_nettype none

package ofd_pkg;

    localparam logic       FUNC_BYTE = 1'b0;
    localparam logic       FUNC_END  = 1'b1;

    localparam logic [7:0] SYNC_BYTE = 8'hAA;
    localparam logic [4:0] FRAME_LEN = 5'd19;
    localparam logic [4:0] CHECK_POS = 5'd18;
    localparam logic [4:0] SUM_FIRST = 5'd2;
    localparam logic [4:0] SUM_LAST  = 5'd17;

    // Bytes 0 to 14 carry the header and the data words.
    localparam int         FIELD_BYTES = 15;
    localparam logic [4:0] FIELD_LEN   = 5'd15;

    typedef struct packed {
        logic               frame_ok;
        logic        [7:0]  sequence_index;
        logic signed [15:0] yaw_centideg;
        logic signed [15:0] pitch_centideg;
        logic signed [15:0] roll_centideg;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } ofd_result_t;

endpackage

`default_nettype wire

>>> hdl/ofd_collect.sv
`default_nettype none

module ofd_collect
    import ofd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_accept,
    input  wire logic        in_func,
    input  wire logic [7:0]  in_byte,
    output logic             res_load,
    output ofd_result_t      res_next
);

    logic [4:0] byte_count_reg;
    logic [4:0] byte_count_next;
    logic [7:0] running_sum_reg;
    logic [7:0] running_sum_next;
    logic [7:0] field_reg [FIELD_BYTES];
    logic [7:0] check_reg;
    logic       frame_ok;
    logic       take_byte;

    assign take_byte = in_accept && (in_func == FUNC_BYTE) && (byte_count_reg < FRAME_LEN);
    assign res_load  = in_accept && (in_func == FUNC_END);

    always_comb begin
        byte_count_next  = byte_count_reg;
        running_sum_next = running_sum_reg;
        if (res_load) begin
            byte_count_next  = 5'd0;
            running_sum_next = 8'd0;
        end else if (take_byte) begin
            byte_count_next = byte_count_reg + 5'd1;
            if (byte_count_reg >= SUM_FIRST && byte_count_reg <= SUM_LAST) begin
                running_sum_next = running_sum_reg + in_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg  <= 5'd0;
            running_sum_reg <= 8'd0;
        end else begin
            byte_count_reg  <= byte_count_next;
            running_sum_reg <= running_sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_byte && byte_count_reg < FIELD_LEN) begin
            field_reg[byte_count_reg[3:0]] <= in_byte;
        end
        if (take_byte && byte_count_reg == CHECK_POS) begin
            check_reg <= in_byte;
        end
    end

    assign frame_ok = (byte_count_reg == FRAME_LEN) &&
                      (field_reg[0] == SYNC_BYTE) &&
                      (field_reg[1] == SYNC_BYTE) &&
                      (running_sum_reg == check_reg);

    always_comb begin
        res_next = '0;
        if (frame_ok) begin
            res_next.frame_ok       = 1'b1;
            res_next.sequence_index = field_reg[2];
            res_next.yaw_centideg   = {field_reg[4], field_reg[3]};
            res_next.pitch_centideg = {field_reg[6], field_reg[5]};
            res_next.roll_centideg  = {field_reg[8], field_reg[7]};
            res_next.accel_x        = {field_reg[10], field_reg[9]};
            res_next.accel_y        = {field_reg[12], field_reg[11]};
            res_next.accel_z        = {field_reg[14], field_reg[13]};
        end
    end

endmodule

`default_nettype wire

>>> hdl/ofd_result_reg.sv
`default_nettype none

module ofd_result_reg
    import ofd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        load,
    input  wire ofd_result_t result_in,
    output logic             free,
    output logic             out_valid,
    input  wire logic        out_ready,
    output ofd_result_t      result_out
);

    logic        valid_reg;
    ofd_result_t result_reg;

    assign free       = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign result_out = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_in;
        end
    end

endmodule

`default_nettype wire

>>> hdl/orientation_frame_deframer.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_func, s_data_byte
// m_        out        m_valid/m_ready    frame result, eight fields
//
// One transaction is taken per cycle; an end-of-burst transaction gives its result
// in the output register in the next cycle. Byte count and checksum are held in
// the collector and reset synchronously; the stored frame bytes are not reset.
// The input stalls only while a result is held and m_ready is low.
`default_nettype none

module orientation_frame_deframer
    import ofd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_func,
    input  wire logic [7:0]         s_data_byte,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_frame_ok,
    output logic        [7:0]       m_sequence_index,
    output logic signed [15:0]      m_yaw_centideg,
    output logic signed [15:0]      m_pitch_centideg,
    output logic signed [15:0]      m_roll_centideg,
    output logic signed [15:0]      m_accel_x,
    output logic signed [15:0]      m_accel_y,
    output logic signed [15:0]      m_accel_z
);

    logic        in_accept;
    logic        res_load;
    ofd_result_t res_next;
    ofd_result_t res_out;

    assign in_accept = s_valid && s_ready;

    ofd_collect u_collect (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_func   (s_func),
        .in_byte   (s_data_byte),
        .res_load  (res_load),
        .res_next  (res_next)
    );

    ofd_result_reg u_result (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (res_load),
        .result_in  (res_next),
        .free       (s_ready),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .result_out (res_out)
    );

    assign m_frame_ok       = res_out.frame_ok;
    assign m_sequence_index = res_out.sequence_index;
    assign m_yaw_centideg   = res_out.yaw_centideg;
    assign m_pitch_centideg = res_out.pitch_centideg;
    assign m_roll_centideg  = res_out.roll_centideg;
    assign m_accel_x        = res_out.accel_x;
    assign m_accel_y        = res_out.accel_y;
    assign m_accel_z        = res_out.accel_z;

endmodule

`default_nettype wire
